@@ rtl/core/sasbc_pkg.sv @@
// ----------------------------------------------------------------------------
// sasbc_pkg: shared types and constants
// Field widths, queue geometry and the structs that pass between the front,
// the queue and the back of the subarray-sum counter.
// ----------------------------------------------------------------------------
`default_nettype none

package sasbc_pkg;

   // Fixed field widths.
   localparam int VALUE_W = 16;
   localparam int THR_W   = 27;
   localparam int WLEN_W  = 11;
   localparam int TOTAL_W = 20;

   // Queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   // One classified element as it travels from front to back.
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
      logic                      ovf;
   } item_type;

   // One result as it sits in the output register.
   typedef struct packed {
      logic [TOTAL_W-1:0] total;
      logic [WLEN_W-1:0]  wlen;
      logic               last;
      logic               ovf;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/core/subarray_sum_below_count.sv @@
// ----------------------------------------------------------------------------
// subarray_sum_below_count: count of subarrays with sum below a threshold
// Streams the elements of an array and returns, for each element, the number
// of subarrays ending there whose sum is below the threshold, and the running total.
// ----------------------------------------------------------------------------
// Path: an element passes the queue, is taken by the back engine in S_IDLE,
// drops front elements one at a time in S_DROP and is posted to the output
// register once it is free; an ignored element is posted straight from S_IDLE.
// No new element is taken while in S_DROP; drops average at most one per element.
// Reset clears the queue, counters, window state and the threshold (to 0); the
// element store itself is not cleared.
`default_nettype none

module subarray_sum_below_count
   import sasbc_pkg::*;
#(
   parameter int MAX_LEN = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input stream.
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] value
   input  wire logic        req_tlast,   // last
   // Result stream.
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata,   // [10:0] window_len, [30:11] total, [31] zero
   output      logic        rsp_tlast,   // is_last
   output      logic [0:0]  rsp_tuser,   // [0] overflow
   // Configuration port.
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);

   localparam logic REG_THRESHOLD = 1'b0;

   logic signed [THR_W-1:0] threshold_ff;
   logic                    q_push;
   logic                    q_pop;
   logic                    q_full;
   logic                    q_empty;
   item_type                push_item;
   item_type                head_item;
   logic                    rsp_valid;
   result_type              rsp_result;

   // Register access; writes complete in the access phase.
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_THRESHOLD) ? 32'(threshold_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[2] == REG_THRESHOLD)) begin
         threshold_ff <= csr_pwdata[THR_W-1:0];
      end
   end

   sasbc_front #(
      .MAX_LEN (MAX_LEN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_value  (req_tdata[VALUE_W-1:0]),
      .req_last   (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   sasbc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head_item (head_item)
   );

   sasbc_back #(
      .MAX_LEN (MAX_LEN)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .threshold  (threshold_ff),
      .q_empty    (q_empty),
      .q_item     (head_item),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_tready),
      .rsp_result (rsp_result)
   );

   // Result packing.
   assign rsp_tvalid   = rsp_valid;
   assign rsp_tdata    = {1'b0, rsp_result.total, rsp_result.wlen};
   assign rsp_tlast    = rsp_result.last;
   assign rsp_tuser[0] = rsp_result.ovf;

   // The back never takes an element from an empty queue.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("pop from empty queue");

   // The front never offers an element into a full queue.
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("push into full queue");

   // An ignored element always reports an empty window.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata[WLEN_W-1:0] == '0))
      else $error("overflow result with nonzero window length");

   // No result is offered in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire

@@ rtl/core/sasbc_front.sv @@
// ----------------------------------------------------------------------------
// sasbc_front: input classifier
// Accepts elements, counts them per array and tags those that arrive once
// the store is full, so that the back can skip them.
// ----------------------------------------------------------------------------
`default_nettype none

module sasbc_front
   import sasbc_pkg::*;
#(
   parameter int MAX_LEN = 1024
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output      logic                      req_tready,
   input  wire logic signed [VALUE_W-1:0] req_value,
   input  wire logic                      req_last,
   input  wire logic                      q_full,
   output      logic                      q_push,
   output      item_type                  q_item
);

   localparam int CNT_W = $clog2(MAX_LEN + 1);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             full_array;

   // The front only stalls when the queue has no room.
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && req_tready;

   // An element is ignored once MAX_LEN elements of this array are stored.
   assign full_array   = (count_ff >= CNT_W'(MAX_LEN));
   assign q_item.value = req_value;
   assign q_item.last  = req_last;
   assign q_item.ovf   = full_array;

   // Element count of the current array; a last element starts a new one.
   always_comb begin
      count_in = count_ff;
      if (q_push) begin
         if (req_last) begin
            count_in = '0;
         end else if (!full_array) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/sasbc_queue.sv @@
// ----------------------------------------------------------------------------
// sasbc_queue: element queue
// A short first-in first-out queue that lets the front keep accepting while
// the back works through the window of an earlier element.
// ----------------------------------------------------------------------------
`default_nettype none

module sasbc_queue
   import sasbc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   input  wire logic     pop,
   output      logic     full,
   output      logic     empty,
   output      item_type head_item
);

   item_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W:0]   count_ff;
   logic [QPTR_W:0]   count_in;

   assign full      = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign head_item = entry_ff[rd_ptr_ff];

   // Occupancy follows the push and pop transfers.
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W + 1)'(1);
      end
   end

   // Pointers and occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/sasbc_back.sv @@
// ----------------------------------------------------------------------------
// sasbc_back: sliding-window engine
// Stores each element not tagged ovf, keeps the window sum, drops front elements one per
// cycle while the sum is at or above the threshold, and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module sasbc_back
   import sasbc_pkg::*;
#(
   parameter int MAX_LEN = 1024
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic signed [THR_W-1:0] threshold,
   input  wire logic                    q_empty,
   input  wire item_type                q_item,
   output      logic                    q_pop,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_ready,
   output      result_type              rsp_result
);

   localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CNT_W = $clog2(MAX_LEN + 1);
   localparam int SUM_W = (VALUE_W + IDX_W + 1 > THR_W) ? VALUE_W + IDX_W + 1 : THR_W;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_DROP = 1'b1;

   logic                      state_ff, state_in;
   logic [CNT_W-1:0]          tail_ff, tail_in;
   logic [CNT_W-1:0]          head_ff, head_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [TOTAL_W-1:0]        total_ff, total_in;
   logic                      last_ff, last_in;
   logic                      out_valid_ff, out_valid_in;
   result_type                out_ff, out_in;

   logic signed [VALUE_W-1:0] store [MAX_LEN];
   logic signed [VALUE_W-1:0] rd_data_ff;
   logic                      wr_en;
   logic [IDX_W-1:0]          wr_addr;
   logic [IDX_W-1:0]          rd_addr;

   logic                      out_free;
   logic                      drop;
   logic [CNT_W-1:0]          wlen;
   logic [TOTAL_W-1:0]        total_sum;

   assign out_free   = !out_valid_ff || rsp_ready;
   assign rsp_valid  = out_valid_ff;
   assign rsp_result = out_ff;

   // The window is non-empty while head trails tail; drop while the sum is high.
   assign drop      = (head_ff != tail_ff) && (sum_ff >= SUM_W'(threshold));
   assign wlen      = tail_ff - head_ff;
   assign total_sum = total_ff + TOTAL_W'(wlen);

   // Sequencer: take an element, drop from the front, post; ignored ones post at once.
   always_comb begin
      state_in     = state_ff;
      tail_in      = tail_ff;
      head_in      = head_ff;
      sum_in       = sum_ff;
      total_in     = total_ff;
      last_in      = last_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_in       = out_ff;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (!q_empty && (!q_item.ovf || out_free)) begin
               q_pop = 1'b1;
               if (q_item.ovf) begin
                  // Ignored element: report it and leave the window alone.
                  out_valid_in = 1'b1;
                  out_in.wlen  = '0;
                  out_in.total = total_ff;
                  out_in.last  = q_item.last;
                  out_in.ovf   = 1'b1;
                  if (q_item.last) begin
                     tail_in  = '0;
                     head_in  = '0;
                     sum_in   = '0;
                     total_in = '0;
                  end
               end else begin
                  wr_en    = 1'b1;
                  sum_in   = sum_ff + SUM_W'(q_item.value);
                  tail_in  = tail_ff + CNT_W'(1);
                  last_in  = q_item.last;
                  state_in = S_DROP;
               end
            end
         end
         S_DROP: begin
            if (drop) begin
               sum_in  = sum_ff - SUM_W'(rd_data_ff);
               head_in = head_ff + CNT_W'(1);
            end else if (out_free) begin
               out_valid_in = 1'b1;
               out_in.wlen  = WLEN_W'(wlen);
               out_in.total = total_sum;
               out_in.last  = last_ff;
               out_in.ovf   = 1'b0;
               total_in     = total_sum;
               state_in     = S_IDLE;
               if (last_ff) begin
                  tail_in  = '0;
                  head_in  = '0;
                  sum_in   = '0;
                  total_in = '0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign wr_addr = tail_ff[IDX_W-1:0];
   assign rd_addr = head_in[IDX_W-1:0];

   // Element store; the read register always holds the window front, with the
   // element written in the same cycle passed straight through.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= q_item.value;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= q_item.value;
      end else begin
         rd_data_ff <= store[rd_addr];
      end
   end

   // Control and window state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tail_ff      <= '0;
         head_ff      <= '0;
         sum_ff       <= '0;
         total_ff     <= '0;
         last_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tail_ff      <= tail_in;
         head_ff      <= head_in;
         sum_ff       <= sum_in;
         total_ff     <= total_in;
         last_ff      <= last_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule

`default_nettype wire

@@ dv/subarray_sum_below_count_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subarray_sum_below_count_checker: result checker for the subarray counter
// Watches the configuration port and both streams. It keeps its own copy of
// the threshold and of the window state, works out the window length and the
// running total for every element transfer, and compares each result transfer
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module subarray_sum_below_count_checker
   import sasbc_pkg::*;
#(
   parameter int         MAX_LEN        = 1024,
   parameter logic [2:0] THRESHOLD_ADDR = 3'd0
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic [0:0]  rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          mismatches,
   output int          results_seen,
   output int          overflows_seen,
   output int          arrays_closed
);

   // One predicted or observed result.
   typedef struct packed {
      logic [WLEN_W-1:0]  window_len;
      logic [TOTAL_W-1:0] total;
      logic               is_last;
      logic               overflow;
   } count_result_type;

   count_result_type          expected_counts[$];
   logic signed [VALUE_W-1:0] elements[MAX_LEN];
   int                        fill;
   int                        front;
   longint                    window_sum;
   longint                    threshold;
   longint unsigned           subarray_total;

   // Returns the window state to that of a fresh array.
   function automatic void open_array();
      fill           = 0;
      front          = 0;
      window_sum     = 0;
      subarray_total = 0;
   endfunction

   // Adds one element, shrinks the window from the front until its sum is below
   // the threshold or it is empty, and returns the counts for this element.
   function automatic count_result_type count_subarrays(
      input logic signed [VALUE_W-1:0] value,
      input logic                      last);
      count_result_type r;
      longint unsigned  span;
      span       = 0;
      r.overflow = 1'b0;
      if (fill >= MAX_LEN) begin
         // The array is already full, so the element is dropped unseen.
         r.overflow = 1'b1;
      end else begin
         elements[fill] = value;
         window_sum    += value;
         while (front <= fill && window_sum >= threshold) begin
            window_sum -= elements[front];
            front++;
         end
         span            = fill + 1 - front;
         subarray_total += span;
         fill++;
      end
      r.window_len = span[WLEN_W-1:0];
      r.total      = subarray_total[TOTAL_W-1:0];
      r.is_last    = last;
      if (last) begin
         open_array();
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input count_result_type want,
                                  input count_result_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("[%0t] %s: expected len %0d total %0d last %0b ovf %0b,",
                  $realtime, what, want.window_len, want.total, want.is_last,
                  want.overflow);
         $display("   got len %0d total %0d last %0b ovf %0b",
                  got.window_len, got.total, got.is_last, got.overflow);
      end
   endtask

   // All transfers are sampled at the rising edge at which they take place.
   always @(posedge clock) begin
      count_result_type want;
      count_result_type got;
      if (reset) begin
         open_array();
         threshold = 0;
         expected_counts.delete();
      end else begin
         // Register write; only THRESHOLD_ADDR is modelled here.
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == THRESHOLD_ADDR) begin
            threshold = $signed(csr_pwdata[THR_W-1:0]);
         end
         if (req_tvalid && req_tready) begin
            expected_counts.push_back(count_subarrays(req_tdata, req_tlast));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.window_len = rsp_tdata[WLEN_W-1:0];
            got.total      = rsp_tdata[WLEN_W +: TOTAL_W];
            got.is_last    = rsp_tlast;
            got.overflow   = rsp_tuser[0];
            results_seen++;
            if (expected_counts.size() == 0) begin
               report_mismatch("result with nothing outstanding", '0, got);
            end else begin
               want = expected_counts.pop_front();
               if (got != want) begin
                  report_mismatch("result mismatch", want, got);
               end
               if (want.overflow) begin
                  overflows_seen++;
               end
               if (want.is_last) begin
                  arrays_closed++;
               end
            end
         end
      end
   end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for subarray_sum_below_count
// Drives arrays of signed elements and threshold writes into the counter with
// random idle cycles on both streams. A directed opening covers the field
// extremes, the emptied window and an unused register address; the random part
// mixes thresholds and array shapes, and includes one array that runs past the
// length limit. The checker instance predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
   import sasbc_pkg::*;

   localparam int         MAX_LEN        = 1024;
   localparam logic [2:0] THRESHOLD_ADDR = 3'd0;
   localparam logic [2:0] SPARE_ADDR     = 3'd4;   // no register behind it
   localparam int         THRESHOLD_MAX  = 67108863;
   localparam int         THRESHOLD_MIN  = -67108864;
   localparam int         ITEM_TARGET    = 1600;
   localparam int         STALL_LIMIT    = 20000;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata   = '0;
   logic        req_tlast   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic [0:0]  rsp_tuser;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // No idling on either stream while this is set.
   logic        calm        = 1'b0;
   int          items_sent  = 0;
   int          thresholds_written = 0;
   int          quiet_cycles = 0;
   int          mismatches;
   int          results_seen;
   int          overflows_seen;
   int          arrays_closed;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   subarray_sum_below_count #(.MAX_LEN(MAX_LEN)) uut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast, .rsp_tuser,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   subarray_sum_below_count_checker #(
      .MAX_LEN(MAX_LEN), .THRESHOLD_ADDR(THRESHOLD_ADDR)
   ) counts_check (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast, .rsp_tuser,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .mismatches, .results_seen, .overflows_seen, .arrays_closed
   );

   // The result side stalls at random.
   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 7);
   end

   // Watchdog: ends the run when no transfer of any kind happens for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one element and waits for its transfer, sometimes idling first.
   task automatic send_element(input int value, input logic last);
      if (!calm && $urandom_range(99) < 7) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < 30) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value[15:0];
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Drops the request and waits until every element sent has its result.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (results_seen < items_sent) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] addr, input int data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_threshold(input int thr);
      settle();
      write_csr(THRESHOLD_ADDR, thr);
      thresholds_written++;
   endtask

   // Sends one array of the given length in one of several shapes.
   task automatic send_array(input int len, input int shape);
      int value;
      for (int i = 0; i < len; i++) begin
         case (shape)
            0: value = int'($urandom_range(0, 65535)) - 32768;
            1: value = int'($urandom_range(0, 600)) - 300;
            default: begin
               // A sag of small values with rare spikes, ending in a spike that can empty the window.
               if (i == len - 1 || $urandom_range(99) < 5) begin
                  value = int'($urandom_range(20000, 32767));
               end else begin
                  value = int'($urandom_range(0, 50)) - 40;
               end
            end
         endcase
         send_element(value, i == len - 1);
      end
   endtask

   initial begin
      int  thr;
      bit  long_done;
      long_done = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Threshold zero from reset: sums at or above zero shrink the window from the front.
      send_element(32767, 1'b0);
      send_element(-32768, 1'b0);
      send_element(-1, 1'b0);
      send_element(0, 1'b0);
      send_element(1, 1'b1);

      // Largest threshold: nothing is ever dropped.
      set_threshold(THRESHOLD_MAX);
      send_element(-32768, 1'b0);
      send_element(32767, 1'b0);
      send_element(32767, 1'b1);

      // Smallest threshold: every element empties the window.
      set_threshold(THRESHOLD_MIN);
      send_element(5, 1'b0);
      send_element(-32768, 1'b1);

      // A write to an unused address must leave the threshold alone.
      settle();
      write_csr(SPARE_ADDR, -1);
      send_element(-7, 1'b1);

      // Moderate threshold with partial drops.
      set_threshold(100);
      send_element(50, 1'b0);
      send_element(60, 1'b0);
      send_element(10, 1'b0);
      send_element(-200, 1'b0);
      send_element(300, 1'b0);
      send_element(99, 1'b0);
      send_element(1, 1'b1);

      // Random phases of thresholds and arrays.
      while (items_sent < ITEM_TARGET) begin
         if (!long_done && items_sent > 300) begin
            // One array past the length limit with no idling at all; the
            // last three elements are ignored and the final one closes it.
            set_threshold(THRESHOLD_MAX);
            calm = 1'b1;
            send_array(MAX_LEN + 3, 0);
            settle();
            calm = 1'b0;
            long_done = 1;
         end
         case ($urandom_range(5))
            0: thr = 0;
            1: thr = int'($urandom_range(1, 4000));
            2: thr = -int'($urandom_range(1, 4000));
            3: begin
               thr = int'($urandom);
               thr = (thr <<< 5) >>> 5;
            end
            4: thr = ($urandom_range(1) != 0) ? THRESHOLD_MAX : THRESHOLD_MIN;
            default: thr = int'($urandom_range(0, 200000)) - 100000;
         endcase
         set_threshold(thr);
         repeat ($urandom_range(3, 8)) begin
            send_array($urandom_range(1, 40), $urandom_range(2));
         end
      end

      // Drain the outstanding results, then give late extras time to appear.
      req_tvalid <= 1'b0;
      while (results_seen < items_sent) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("Sent %0d elements over %0d threshold settings; %0d arrays closed.",
               items_sent, thresholds_written, arrays_closed);
      $display("%0d elements were ignored past the length limit; %0d mismatches.",
               overflows_seen, mismatches);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/sasbc_pkg.sv
rtl/core/sasbc_front.sv
rtl/core/sasbc_queue.sv
rtl/core/sasbc_back.sv
rtl/core/subarray_sum_below_count.sv
dv/subarray_sum_below_count_checker.sv
dv/tb.sv
